// ----- rtl/hll_flux_combiner_unit_defines.svh -----
`ifndef HLL_FLUX_COMBINER_UNIT_DEFINES_SVH
`define HLL_FLUX_COMBINER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hfc_pkg.sv -----
`timescale 1ns / 1ps
package hfc_pkg;

  localparam int DEN_W = 33;
  localparam int QUO_W = 33;
  localparam int IN_W  = 192;

  typedef enum logic [1:0] {
    REG_LEFT  = 2'd0,
    REG_RIGHT = 2'd1,
    REG_MID   = 2'd2
  } region_t;

  typedef struct packed {
    logic signed [31:0] flux_pass;
    logic [30:0]        max_speed;
    region_t            region;
    logic               degen;
    logic               last;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             ovf;
  } div_t;

  localparam logic [31:0] FLUX_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] FLUX_NEG_MAG = 32'h8000_0000;

endpackage

// ----- rtl/hll_flux_combiner_unit.sv -----
// HLL flux combiner: one conserved component per request.
// Input channel in_*: tdata carries SL, SR, fL, fR, uL, uR (signed Q16.16 by
// default, FRAC_BITS fraction bits), tlast marks the last component of a sweep.
// Output channel out_*: tdata carries the HLL flux and max(|SL|,|SR|); tuser
// carries the region code, the zero-gap flag and the clip flag; tlast follows
// the input tlast.
// The pipe runs multiply and numerator build, then restoring division (one
// quotient bit per stage), then saturation into the output register. One
// request is taken every cycle while the output is not stalled; items are
// independent and travel the pipe with their own valid bit.
// All stages share one enable: while out_tvalid is high and out_tready low,
// the whole pipe holds and in_tready is low; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; payload registers
// are not reset.
`timescale 1ns / 1ps
`include "hll_flux_combiner_unit_defines.svh"
module hll_flux_combiner_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] left_speed, [63:32] right_speed, [95:64] flux_left,
  // [127:96] flux_right, [159:128] cons_left, [191:160] cons_right
  input  logic [191:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] hll_flux, [62:32] max_speed, [63] zero pad
  output logic [63:0]  out_tdata,
  // [1:0] region, [2] degenerate, [3] saturated
  output logic [3:0]   out_tuser,
  output logic         out_tlast
);
  import hfc_pkg::*;

  logic  en;
  logic  vs [QUO_W+1];
  div_t  ds [QUO_W+1];
  side_t ss [QUO_W+1];

  div_t         dl;
  side_t        sl;
  logic [31:0]  lim;
  logic         sat_nxt;
  logic [31:0]  m;
  logic [31:0]  flux_nxt;
  logic         sat_flag;

  logic         out_v_r;
  logic [31:0]  flux_r;
  logic [30:0]  ms_r;
  region_t      region_r;
  logic         degen_r, sat_r, last_r;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  hfc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .out_valid(vs[0]),
    .out_div  (ds[0]),
    .out_side (ss[0])
  );

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    hfc_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (vs[g]),
      .in_div   (ds[g]),
      .in_side  (ss[g]),
      .out_valid(vs[g+1]),
      .out_div  (ds[g+1]),
      .out_side (ss[g+1])
    );
  end

  assign dl = ds[QUO_W];
  assign sl = ss[QUO_W];

  always_comb begin
    lim      = dl.neg ? FLUX_NEG_MAG : FLUX_POS_MAX;
    sat_nxt  = dl.ovf || (dl.quo > {1'b0, lim});
    m        = sat_nxt ? lim : dl.quo[31:0];
    flux_nxt = dl.neg ? 32'(-m) : m;
    sat_flag = 1'b0;
    if (sl.region != REG_MID) begin
      flux_nxt = sl.flux_pass;
    end else if (sl.degen) begin
      flux_nxt = '0;
    end else begin
      sat_flag = sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= vs[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flux_r   <= flux_nxt;
      ms_r     <= sl.max_speed;
      region_r <= sl.region;
      degen_r  <= sl.degen;
      sat_r    <= sat_flag;
      last_r   <= sl.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, ms_r, flux_r};
  assign out_tuser  = {sat_r, degen_r, region_r};
  assign out_tlast  = last_r;

  `HFC_ASSERT_NOW(a_upwind_clean, out_tvalid && region_r != REG_MID, !degen_r && !sat_r, "upwind result flagged")
  `HFC_ASSERT_NOW(a_degen_zero, out_tvalid && degen_r, flux_r == 32'd0 && region_r == REG_MID && !sat_r, "zero gap result not zero")
  `HFC_ASSERT_NOW(a_sat_limit, out_tvalid && sat_r, flux_r == FLUX_POS_MAX || flux_r == FLUX_NEG_MAG, "clipped flux off limit")
  `HFC_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled pipe moved")

endmodule

// ----- rtl/hfc_front.sv -----
`timescale 1ns / 1ps
module hfc_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [191:0]          in_data,
  input  logic                  in_last,
  output logic                  out_valid,
  output hfc_pkg::div_t         out_div,
  output hfc_pkg::side_t        out_side
);
  import hfc_pkg::*;

  localparam int NW  = ((65 + FRAC_BITS) > 96 ? (65 + FRAC_BITS) : 96) + 1;
  localparam int NPW = NW - FRAC_BITS;
  localparam int HW  = NPW - QUO_W;

  logic               v_r [6];
  side_t              side_r [6];

  logic signed [31:0] sl, sr, fl, fr, ul, ur;
  logic [31:0]        ml, mr, ms;
  side_t              side1_nxt;

  // stage 1: products, differences, region decode
  logic signed [63:0] p_rl_r, p_lr_r, p_ss_r;
  logic signed [32:0] du_r;
  logic [DEN_W-1:0]   den1_r;

  // stage 2
  logic [63:0]        t_full;
  logic signed [64:0] a_r;
  logic signed [65:0] pl_r;
  logic signed [64:0] ph_r;
  logic [DEN_W-1:0]   den2_r;

  // stage 3..6
  logic signed [NW-1:0] m_r, ash_r, n_r;
  logic [DEN_W-1:0]     den3_r, den4_r, den5_r;
  logic [NW-1:0]        mag;
  logic [NPW-1:0]       np_r;
  logic                 neg_r;
  logic [HW-1:0]        hi;
  div_t                 div_r;

  assign sl = in_data[31:0];
  assign sr = in_data[63:32];
  assign fl = in_data[95:64];
  assign fr = in_data[127:96];
  assign ul = in_data[159:128];
  assign ur = in_data[191:160];

  always_comb begin
    ml = sl[31] ? 32'(-sl) : 32'(sl);
    mr = sr[31] ? 32'(-sr) : 32'(sr);
    ms = (ml > mr) ? ml : mr;
    side1_nxt.max_speed = ms[31] ? 31'h7FFF_FFFF : ms[30:0];
    side1_nxt.last      = in_last;
    side1_nxt.degen     = 1'b0;
    if (sl > 0) begin
      side1_nxt.region    = REG_LEFT;
      side1_nxt.flux_pass = fl;
    end else if (sr < 0) begin
      side1_nxt.region    = REG_RIGHT;
      side1_nxt.flux_pass = fr;
    end else begin
      side1_nxt.region    = REG_MID;
      side1_nxt.flux_pass = fr;
      side1_nxt.degen     = (sl == sr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < 6; i++) v_r[i] <= v_r[i-1];
    end
  end

  assign t_full = 64'(-p_ss_r);
  assign mag    = n_r[NW-1] ? NW'(-n_r) : NW'(n_r);
  assign hi     = np_r[NPW-1:QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side1_nxt;
      for (int i = 1; i < 6; i++) side_r[i] <= side_r[i-1];

      p_rl_r <= sr * fl;
      p_lr_r <= sl * fr;
      p_ss_r <= sl * sr;
      du_r   <= $signed({ur[31], ur}) - $signed({ul[31], ul});
      den1_r <= DEN_W'({sr[31], sr} - {sl[31], sl});

      // SL <= 0 <= SR here, so SL*SR is never positive
      a_r    <= $signed({p_rl_r[63], p_rl_r}) - $signed({p_lr_r[63], p_lr_r});
      pl_r   <= $signed({1'b0, t_full[31:0]}) * du_r;
      ph_r   <= $signed({1'b0, t_full[62:32]}) * du_r;
      den2_r <= den1_r;

      m_r    <= (NW'(ph_r) <<< 32) + NW'(pl_r);
      ash_r  <= NW'(a_r) <<< FRAC_BITS;
      den3_r <= den2_r;

      n_r    <= ash_r - m_r;
      den4_r <= den3_r;

      neg_r  <= n_r[NW-1];
      np_r   <= mag[NW-1:FRAC_BITS];
      den5_r <= den4_r;

      div_r.ovf <= (hi >= HW'(den5_r));
      div_r.rem <= hi[DEN_W-1:0];
      div_r.num <= np_r[QUO_W-1:0];
      div_r.quo <= '0;
      div_r.den <= den5_r;
      div_r.neg <= neg_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_side  = side_r[5];
  assign out_div   = div_r;

endmodule

// ----- rtl/hfc_div_step.sv -----
`timescale 1ns / 1ps
module hfc_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hfc_pkg::div_t  in_div,
  input  hfc_pkg::side_t in_side,
  output logic           out_valid,
  output hfc_pkg::div_t  out_div,
  output hfc_pkg::side_t out_side
);
  import hfc_pkg::*;

  logic [DEN_W:0] r2, diff;
  logic           ge;
  div_t           div_nxt;
  logic           v_r;
  div_t           div_r;
  side_t          side_r;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    r2      = {in_div.rem, in_div.num[QUO_W-1]};
    diff    = r2 - {1'b0, in_div.den};
    ge      = (r2 >= {1'b0, in_div.den});
    div_nxt = in_div;
    div_nxt.rem = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
    div_nxt.num = {in_div.num[QUO_W-2:0], 1'b0};
    div_nxt.quo = {in_div.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule
